// ----- sv/doa_report_on_change_filter_defines.svh -----
// Assertion helpers used by the filter tracking stage (doa_track).
`ifndef DOA_REPORT_ON_CHANGE_FILTER_DEFINES_SVH
`define DOA_REPORT_ON_CHANGE_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DOA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("doa filter: assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DOA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("doa filter: assertion failed");

`endif

// ----- sv/doa_pkg.sv -----
`default_nettype none

package doa_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] RegMaxFailures = 2'd0;
  localparam logic [CfgIdxW-1:0] RegAngleDb     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegConfDb      = 2'd2;

  localparam logic [7:0] MaxFailuresRst = 8'd3;
  localparam logic [7:0] AngleDbRst     = 8'd2;
  localparam logic [6:0] ConfDbRst      = 7'd5;

  // Value ranges
  localparam int unsigned ModeMax  = 2;
  localparam int unsigned ConfMax  = 100;
  localparam int unsigned AngleMod = 360;
  localparam int unsigned AngleHalf = AngleMod / 2;

  // Angle reduction: the 32-bit word is folded byte by byte with the weights
  // 2^(8i) mod 360, then the folded sum is divided by 360 with a reciprocal.
  localparam int unsigned SumW        = 17;
  localparam int unsigned QuoW        = 9;
  localparam int unsigned RecipShift  = 26;
  localparam int unsigned RecipW      = 18;
  localparam int unsigned AngleRecip  = (1 << RecipShift) / AngleMod;
  localparam int unsigned ProdW       = SumW + RecipW;
  localparam int unsigned WeightB2    = (1 << 16) % AngleMod;                    // 16
  localparam int unsigned WeightB3    = (WeightB2 * 256) % AngleMod;             // 136
  localparam int unsigned SignOffset  = AngleMod - ((WeightB3 * 256) % AngleMod); // 104

  typedef struct packed {
    logic [7:0] fail_limit;
    logic [7:0] angle_deadband;
    logic [6:0] confidence_deadband;
  } cfg_t;

  // Between the normalize stage and the tracking stage
  typedef struct packed {
    logic            link_up;
    logic            transfer_ok;
    logic            mode_bad;
    logic [1:0]      mode;
    logic [SumW-1:0] angle_sum;
    logic [QuoW-1:0] angle_quo;
    logic [6:0]      confidence;
  } mid_t;

  typedef struct packed {
    logic       backoff;
    logic       parse_error;
    logic       mode_report;
    logic [1:0] mode_value;
    logic       angle_report;
    logic [8:0] angle_value;
    logic       confidence_report;
    logic [6:0] confidence_value;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/doa_if.sv -----
`default_nettype none

interface doa_in_if;
  logic               valid;
  logic               ready;
  logic               link_up;
  logic               transfer_ok;
  logic [7:0]         resp_mode;
  logic signed [31:0] resp_angle;
  logic [23:0]        resp_confidence;

  modport source (
    output valid, link_up, transfer_ok, resp_mode, resp_angle, resp_confidence,
    input  ready
  );
  modport sink (
    input  valid, link_up, transfer_ok, resp_mode, resp_angle, resp_confidence,
    output ready
  );
endinterface

interface doa_out_if;
  logic       valid;
  logic       ready;
  logic       backoff;
  logic       parse_error;
  logic       mode_report;
  logic [1:0] mode_value;
  logic       angle_report;
  logic [8:0] angle_value;
  logic       confidence_report;
  logic [6:0] confidence_value;

  modport source (
    output valid, backoff, parse_error, mode_report, mode_value, angle_report,
           angle_value, confidence_report, confidence_value,
    input  ready
  );
  modport sink (
    input  valid, backoff, parse_error, mode_report, mode_value, angle_report,
           angle_value, confidence_report, confidence_value,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/doa_norm.sv -----
`default_nettype none

module doa_norm (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  doa_in_if.sink         in_if,
  output doa_pkg::mid_t  mid_o,
  output logic           mid_valid_o,
  input  wire logic      mid_ready_i
);
  import doa_pkg::*;

  logic               in_valid_q;
  logic               link_q;
  logic               ok_q;
  logic [7:0]         mode_q;
  logic [31:0]        angle_q;
  logic [23:0]        conf_q;

  logic               mid_valid_q;
  mid_t               mid_q;
  mid_t               mid_d;

  logic               mid_en;
  logic               in_fire;
  logic               in_take;
  logic [SumW-1:0]    sum;
  logic [ProdW-1:0]   prod;

  assign mid_en      = !mid_valid_q || mid_ready_i;
  assign in_fire     = in_valid_q && mid_en;
  assign in_if.ready = !in_valid_q || mid_en;
  assign in_take     = in_if.valid && in_if.ready;

  // Fold to a non-negative value congruent to the signed angle mod 360
  always_comb begin
    sum = SumW'(angle_q[7:0])
        + SumW'({angle_q[15:8], 8'b0})
        + SumW'(angle_q[23:16]) * SumW'(WeightB2)
        + SumW'(angle_q[31:24]) * SumW'(WeightB3)
        + (angle_q[31] ? SumW'(SignOffset) : SumW'(0));
    prod = ProdW'(sum) * ProdW'(AngleRecip);
  end

  always_comb begin
    mid_d.link_up     = link_q;
    mid_d.transfer_ok = ok_q;
    mid_d.mode_bad    = mode_q > 8'(ModeMax);
    mid_d.mode        = mode_q[1:0];
    mid_d.angle_sum   = sum;
    // may be one short; corrected after the remainder
    mid_d.angle_quo   = QuoW'(prod >> RecipShift);
    mid_d.confidence  = (conf_q > 24'(ConfMax)) ? 7'(ConfMax) : conf_q[6:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mid_valid_q <= 1'b0;
    end else begin
      if (in_if.ready) in_valid_q <= in_if.valid;
      if (mid_en) mid_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      link_q  <= in_if.link_up;
      ok_q    <= in_if.transfer_ok;
      mode_q  <= in_if.resp_mode;
      angle_q <= in_if.resp_angle;
      conf_q  <= in_if.resp_confidence;
    end
    if (in_fire) mid_q <= mid_d;
  end

  assign mid_o       = mid_q;
  assign mid_valid_o = mid_valid_q;

endmodule

`default_nettype wire

// ----- sv/doa_track.sv -----
`default_nettype none

module doa_track (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire doa_pkg::cfg_t  cfg_i,
  input  wire doa_pkg::mid_t  mid_i,
  input  wire logic           mid_valid_i,
  output logic                mid_ready_o,
  doa_out_if.source           out_if
);
  import doa_pkg::*;

  `include "doa_report_on_change_filter_defines.svh"

  logic        out_valid_q;
  res_t        res_q;
  res_t        res_d;

  logic [7:0]  fail_cnt_q, fail_cnt_d;
  logic [1:0]  last_mode_q, last_mode_d;
  logic        mode_seen_q, mode_seen_d;
  logic [8:0]  last_angle_q, last_angle_d;
  logic        angle_seen_q, angle_seen_d;
  logic [6:0]  last_conf_q, last_conf_d;
  logic        conf_seen_q, conf_seen_d;

  logic        out_en;
  logic        load;
  logic [SumW-1:0] rem_full;
  logic [9:0]  rem;
  logic [8:0]  angle;
  logic [8:0]  adiff_raw;
  logic [8:0]  adiff;
  logic [6:0]  cdiff;
  logic [7:0]  fail_inc;
  logic        angle_hit;
  logic        conf_hit;
  logic        mode_hit;

  assign out_en      = !out_valid_q || out_if.ready;
  assign mid_ready_o = out_en;
  assign load        = mid_valid_i && out_en;

  // Remainder; the quotient estimate is at most one low
  always_comb begin
    rem_full = mid_i.angle_sum - SumW'(mid_i.angle_quo) * SumW'(AngleMod);
    rem      = rem_full[9:0];
    angle    = (rem >= 10'(AngleMod)) ? 9'(rem - 10'(AngleMod)) : rem[8:0];
  end

  // Circular and linear distances from the last reported values
  always_comb begin
    adiff_raw = (angle >= last_angle_q) ? angle - last_angle_q : last_angle_q - angle;
    adiff     = (adiff_raw > 9'(AngleHalf)) ? 9'(AngleMod) - adiff_raw : adiff_raw;
    cdiff     = (mid_i.confidence >= last_conf_q) ? mid_i.confidence - last_conf_q
                                                  : last_conf_q - mid_i.confidence;
    mode_hit  = !mode_seen_q || (mid_i.mode != last_mode_q);
    angle_hit = !angle_seen_q || (adiff > {1'b0, cfg_i.angle_deadband});
    conf_hit  = !conf_seen_q || (cdiff > cfg_i.confidence_deadband);
    fail_inc  = fail_cnt_q + 8'd1;
  end

  always_comb begin
    res_d        = '0;
    fail_cnt_d   = fail_cnt_q;
    last_mode_d  = last_mode_q;
    mode_seen_d  = mode_seen_q;
    last_angle_d = last_angle_q;
    angle_seen_d = angle_seen_q;
    last_conf_d  = last_conf_q;
    conf_seen_d  = conf_seen_q;
    if (!mid_i.link_up) begin
      fail_cnt_d = '0;
    end else if (!mid_i.transfer_ok) begin
      if (fail_inc >= cfg_i.fail_limit) begin
        res_d.backoff = 1'b1;
        fail_cnt_d    = '0;
      end else begin
        fail_cnt_d = fail_inc;
      end
    end else begin
      fail_cnt_d = '0;
      if (mid_i.mode_bad) begin
        res_d.parse_error = 1'b1;
      end else begin
        res_d.mode_value       = mid_i.mode;
        res_d.angle_value      = angle;
        res_d.confidence_value = mid_i.confidence;
        if (mode_hit) begin
          res_d.mode_report = 1'b1;
          last_mode_d       = mid_i.mode;
          mode_seen_d       = 1'b1;
        end
        if (angle_hit) begin
          res_d.angle_report = 1'b1;
          last_angle_d       = angle;
          angle_seen_d       = 1'b1;
        end
        if (conf_hit) begin
          res_d.confidence_report = 1'b1;
          last_conf_d             = mid_i.confidence;
          conf_seen_d             = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      fail_cnt_q   <= '0;
      last_mode_q  <= '0;
      mode_seen_q  <= 1'b0;
      last_angle_q <= '0;
      angle_seen_q <= 1'b0;
      last_conf_q  <= '0;
      conf_seen_q  <= 1'b0;
    end else begin
      if (out_en) out_valid_q <= mid_valid_i;
      if (load) begin
        fail_cnt_q   <= fail_cnt_d;
        last_mode_q  <= last_mode_d;
        mode_seen_q  <= mode_seen_d;
        last_angle_q <= last_angle_d;
        angle_seen_q <= angle_seen_d;
        last_conf_q  <= last_conf_d;
        conf_seen_q  <= conf_seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) res_q <= res_d;
  end

  assign out_if.valid             = out_valid_q;
  assign out_if.backoff           = res_q.backoff;
  assign out_if.parse_error       = res_q.parse_error;
  assign out_if.mode_report       = res_q.mode_report;
  assign out_if.mode_value        = res_q.mode_value;
  assign out_if.angle_report      = res_q.angle_report;
  assign out_if.angle_value       = res_q.angle_value;
  assign out_if.confidence_report = res_q.confidence_report;
  assign out_if.confidence_value  = res_q.confidence_value;

  `DOA_ASSERT_IMPL(a_angle_range, out_valid_q, res_q.angle_value < 9'(AngleMod))
  `DOA_ASSERT_IMPL(a_angle_tracked, out_valid_q && res_q.angle_report,
                   angle_seen_q && (last_angle_q == res_q.angle_value))
  `DOA_ASSERT_IMPL(a_backoff_clears, out_valid_q && res_q.backoff,
                   (fail_cnt_q == 8'd0) && !res_q.mode_report && !res_q.angle_report)
  `DOA_ASSERT_NEXT(a_stall_holds_state, !load,
                   $stable(last_angle_q) && $stable(last_conf_q) && $stable(fail_cnt_q))

endmodule

`default_nettype wire

// ----- sv/doa_report_on_change_filter.sv -----
// Report-on-change filter for direction-of-arrival sensor polls.
// Input channel in_if: one request per poll slot (link flag, transfer flag,
// raw mode byte, signed 32-bit angle, 24-bit confidence). Output channel
// out_if: exactly one result per request, in order, carrying backoff,
// parse_error, the report flags and the normalized mode/angle/confidence.
// Both channels move a request on a clock edge with valid and ready high.
// A request passes through the input register, the normalize register and
// the result register. Throughput: one request per cycle while out_if is
// not stalled; the angle fold/reciprocal unit and the deadband compare each
// take one stage, with tracking state in the last one. A stalled receiver
// holds the result register; the two earlier registers keep taking requests
// until they are full, then in_if.ready drops.
// Configuration: cfg_we_i writes register cfg_idx_i (0 failure limit,
// 1 angle_deadband, 2 confidence_deadband); write only while idle.
// Reset (rst_ni low, asynchronous) empties the pipeline, clears the failure
// count and reported values, and loads configuration defaults 3, 2 and 5.
`default_nettype none

module doa_report_on_change_filter (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  doa_in_if.sink                               in_if,
  doa_out_if.source                            out_if,
  input  wire logic                            cfg_we_i,
  input  wire logic [doa_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [doa_pkg::CfgDataW-1:0]    cfg_data_i
);
  import doa_pkg::*;

  cfg_t cfg_q;
  mid_t mid;
  logic mid_valid;
  logic mid_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fail_limit          <= MaxFailuresRst;
      cfg_q.angle_deadband      <= AngleDbRst;
      cfg_q.confidence_deadband <= ConfDbRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMaxFailures: cfg_q.fail_limit          <= cfg_data_i[7:0];
        RegAngleDb:     cfg_q.angle_deadband      <= cfg_data_i[7:0];
        RegConfDb:      cfg_q.confidence_deadband <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  doa_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .mid_o       (mid),
    .mid_valid_o (mid_valid),
    .mid_ready_i (mid_ready)
  );

  doa_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_i       (mid),
    .mid_valid_i (mid_valid),
    .mid_ready_o (mid_ready),
    .out_if      (out_if)
  );

endmodule

`default_nettype wire
